FILE: rtl/dbdl_pkg.sv
// Shared types and constants for the debounced button door lock.
package dbdl_pkg;

  // Width of the debounce ceiling register
  localparam int unsigned MaxWidth = 16;

  // Ceiling value after reset
  localparam logic [MaxWidth-1:0] DebounceReset = 16'd16000;

  // Door machine states, encoded as the reported door code
  typedef enum logic [1:0] {
    DOOR_LOCKED = 2'd0,
    DOOR_CLOSED = 2'd1,
    DOOR_OPEN   = 2'd2
  } door_e;

  // One flag per button, passed between debouncers and the door machine
  typedef struct packed {
    logic a;
    logic b;
  } btn_flags_t;

endpackage

FILE: rtl/debounced_button_door_lock_fsm.sv
// Top level of the debounced two-button door lock with its result register.
//
// Usage: each input request is one poll tick carrying the raw levels of
// buttons A and B. Two integrator debouncers turn settled presses into
// events; the door machine (locked, closed, open) consumes them. Every
// request yields exactly one result: the three lamps for the state before
// the tick and the door code after it.
// The result is in the output register the cycle after the request is
// accepted. Throughput: one request per cycle while no held result is
// stalled; the counters and the door state update on each accepted request.
// The receiver may stall: the result register holds its payload, and a new
// request is still taken in the same cycle the held result is taken.
// Input stall rises only while a result is held and the receiver stalls.
// Reset clears counters, flags and events, puts the door in locked, loads
// the ceiling with 16000 and empties the result register.
// The ceiling register is written with cfg_we_i; the user must write it only while the block is idle (not enforced).
module debounced_button_door_lock_fsm #(
  parameter int unsigned CountWidth = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        button_a_i,
  input  logic        button_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        red_lamp_o,
  output logic        blue_lamp_o,
  output logic        green_lamp_o,
  output logic [1:0]  door_state_o
);
  import dbdl_pkg::*;

  logic [MaxWidth-1:0] debounce_max_q;
  logic                tick;
  btn_flags_t          events, clears;
  logic                red_d, blue_d, green_d;
  logic [1:0]          door_d;
  logic                out_valid_q;
  logic                red_q, blue_q, green_q;
  logic [1:0]          door_q;

  // Request handshake: blocked only while a held result is stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign tick       = in_valid_i & ~in_stall_o;

  // Ceiling register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_max_q <= DebounceReset;
    end else if (cfg_we_i) begin
      debounce_max_q <= cfg_wdata_i;
    end
  end

  dbdl_debounce #(.CountWidth(CountWidth)) u_deb_a (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .pressed_i      (button_a_i),
    .debounce_max_i (debounce_max_q),
    .clear_i        (clears.a),
    .event_o        (events.a)
  );

  dbdl_debounce #(.CountWidth(CountWidth)) u_deb_b (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .pressed_i      (button_b_i),
    .debounce_max_i (debounce_max_q),
    .clear_i        (clears.b),
    .event_o        (events.b)
  );

  dbdl_door_fsm u_door (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .events_i     (events),
    .clear_o      (clears),
    .red_lamp_o   (red_d),
    .blue_lamp_o  (blue_d),
    .green_lamp_o (green_d),
    .door_state_o (door_d)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (tick) begin
      red_q   <= red_d;
      blue_q  <= blue_d;
      green_q <= green_d;
      door_q  <= door_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_lamp_o   = red_q;
  assign blue_lamp_o  = blue_q;
  assign green_lamp_o = green_q;
  assign door_state_o = door_q;

endmodule

FILE: rtl/dbdl_debounce.sv
// Integrator debouncer for one button with an armed flag and a sticky press event.
module dbdl_debounce #(
  parameter int unsigned CountWidth = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tick_i,
  input  logic                           pressed_i,
  input  logic [dbdl_pkg::MaxWidth-1:0]  debounce_max_i,
  input  logic                           clear_i,
  output logic                           event_o
);
  import dbdl_pkg::*;

  localparam int unsigned CmpWidth = (CountWidth > MaxWidth) ? CountWidth : MaxWidth;

  logic [CountWidth-1:0] count_q, count_d;
  logic                  armed_q, armed_d;
  logic                  event_q, event_d;
  logic [CmpWidth-1:0]   count_ext, next_ext, max_ext;
  logic                  evt_now;

  assign count_ext = CmpWidth'(count_q);
  assign next_ext  = CmpWidth'(count_d);
  assign max_ext   = CmpWidth'(debounce_max_i);

  // Integrate toward the pressed or released level, saturating at both ends
  always_comb begin
    count_d = count_q;
    armed_d = armed_q;
    evt_now = event_q;
    if (!pressed_i) begin
      if (count_q != '0) begin
        count_d = count_q - CountWidth'(1);
      end else begin
        armed_d = 1'b1;
      end
    end else if ((count_ext < max_ext) && (count_q != '1)) begin
      count_d = count_q + CountWidth'(1);
    end
    // Settled press while armed: latch the event and disarm
    if ((count_d != '0) && (next_ext == max_ext) && armed_d) begin
      evt_now = 1'b1;
      armed_d = 1'b0;
    end
  end

  assign event_d = evt_now & ~clear_i;
  assign event_o = evt_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      armed_q <= 1'b0;
      event_q <= 1'b0;
    end else if (tick_i) begin
      count_q <= count_d;
      armed_q <= armed_d;
      event_q <= event_d;
    end
  end

endmodule

FILE: rtl/dbdl_door_fsm.sv
// Three-state door machine driven by the debounced press events.
module dbdl_door_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  dbdl_pkg::btn_flags_t events_i,
  output dbdl_pkg::btn_flags_t clear_o,
  output logic                 red_lamp_o,
  output logic                 blue_lamp_o,
  output logic                 green_lamp_o,
  output logic [1:0]           door_state_o
);
  import dbdl_pkg::*;

  door_e state_q, state_d;

  // Next state and event clearing
  always_comb begin
    state_d = state_q;
    clear_o = '0;
    case (state_q)
      DOOR_LOCKED: begin
        if (events_i.b) begin
          state_d = DOOR_CLOSED;
          clear_o = '{a: 1'b1, b: 1'b1};
        end
      end
      DOOR_CLOSED: begin
        if (events_i.a) begin
          state_d   = DOOR_OPEN;
          clear_o.a = 1'b1;
        end else if (events_i.b) begin
          state_d   = DOOR_LOCKED;
          clear_o.b = 1'b1;
        end
      end
      DOOR_OPEN: begin
        if (events_i.a) begin
          state_d = DOOR_CLOSED;
          clear_o = '{a: 1'b1, b: 1'b1};
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  // Lamps show the state before the step
  always_comb begin
    red_lamp_o   = 1'b0;
    blue_lamp_o  = 1'b0;
    green_lamp_o = 1'b0;
    case (state_q)
      DOOR_LOCKED: red_lamp_o   = 1'b1;
      DOOR_CLOSED: blue_lamp_o  = 1'b1;
      DOOR_OPEN:   green_lamp_o = 1'b1;
      default:     red_lamp_o   = 1'b0;
    endcase
  end

  assign door_state_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DOOR_LOCKED;
    end else if (tick_i) begin
      state_q <= state_d;
    end
  end

endmodule
